### sv/heightmap_bilinear_sampler_core_macros.svh
// assertion macros for the heightmap sampler
// no dependencies; included by the modules that carry assertions
`ifndef HEIGHTMAP_BILINEAR_SAMPLER_CORE_MACROS_SVH
`define HEIGHTMAP_BILINEAR_SAMPLER_CORE_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define HBS_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is low
`define HBS_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### sv/hbs_pkg.sv
// shared types, codes and arithmetic helpers of the heightmap sampler
// no dependencies; imported by hbs_ctrl, hbs_datapath and the top level of the block
package hbs_pkg;

    localparam int CFG_DATA_W = 16;

    typedef logic [1:0] t_cfg_idx;
    localparam t_cfg_idx CFG_MAP_WIDTH     = 2'd0;
    localparam t_cfg_idx CFG_MAP_DEPTH     = 2'd1;
    localparam t_cfg_idx CFG_HEIGHT_SCALE  = 2'd2;
    localparam t_cfg_idx CFG_HEIGHT_OFFSET = 2'd3;

    localparam logic [8:0]  RST_MAP_WIDTH     = 9'd256;
    localparam logic [8:0]  RST_MAP_DEPTH     = 9'd256;
    localparam logic [14:0] RST_HEIGHT_SCALE  = 15'd16384;
    localparam logic [15:0] RST_HEIGHT_OFFSET = 16'hE200;

    localparam logic KIND_LOAD  = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    // bit 0 steps one column, bit 1 steps one row
    typedef logic [1:0] t_corner;
    localparam t_corner CORNER_A00 = 2'b00;
    localparam t_corner CORNER_A01 = 2'b01;
    localparam t_corner CORNER_A10 = 2'b10;
    localparam t_corner CORNER_A11 = 2'b11;

    // ceil(2^32 / 255), exact floor division for dividends below 2^23
    localparam logic [24:0] RECIP_255 = 25'h1010102;

    typedef struct packed {
        logic    write;
        logic    capture;
        logic    rd_en;
        t_corner corner;
        logic    lat_a;
        logic    h0_en;
        logic    h1_en;
        logic    hz_en;
        logic    scl_en;
        logic    div_en;
        logic    push;
    } t_dp_cmd;

    typedef struct packed {
        logic outside;
        logic out_stall;
    } t_dp_sts;

    function automatic logic [15:0] lerp8(input logic [7:0] a, input logic [7:0] b,
                                          input logic [7:0] f);
        logic [8:0]  fi;
        logic [16:0] s;
        fi = 9'd256 - {1'b0, f};
        s  = {9'd0, a} * {8'd0, fi} + {9'd0, b} * {9'd0, f};
        return s[15:0];
    endfunction

    function automatic logic [23:0] lerp16(input logic [15:0] a, input logic [15:0] b,
                                           input logic [7:0] f);
        logic [8:0]  fi;
        logic [24:0] s;
        fi = 9'd256 - {1'b0, f};
        s  = {9'd0, a} * {16'd0, fi} + {9'd0, b} * {17'd0, f};
        return s[23:0];
    endfunction

endpackage

### sv/hbs_in_if.sv
// input channel of the heightmap sampler: load and query beats
// no dependencies
interface hbs_in_if;
    logic               valid;
    logic               ready;
    logic               kind;
    logic [7:0]         cell_col;
    logic [7:0]         cell_row;
    logic [7:0]         sample;
    logic signed [15:0] world_x;
    logic signed [15:0] world_z;

    modport source (output valid, kind, cell_col, cell_row, sample, world_x, world_z,
                    input ready);
    modport sink   (input valid, kind, cell_col, cell_row, sample, world_x, world_z,
                    output ready);
endinterface

### sv/hbs_out_if.sv
// result channel of the heightmap sampler
// no dependencies
interface hbs_out_if;
    logic               valid;
    logic               ready;
    logic signed [16:0] height_value;
    logic               outside;

    modport source (output valid, height_value, outside, input ready);
    modport sink   (input valid, height_value, outside, output ready);
endinterface

### sv/hbs_ram.sv
// generic single-port ram with registered read
// no dependencies
module hbs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_en,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_we) begin
                r_mem[i_addr] <= i_wdata;
            end else begin
                r_rdata <= r_mem[i_addr];
            end
        end
    end

    assign o_rdata = r_rdata;
endmodule

### sv/hbs_ctrl.sv
// sequencer of the heightmap sampler: handshake, corner reads, arithmetic steps
// depends on hbs_pkg and the assertion macro header
`include "heightmap_bilinear_sampler_core_macros.svh"

module hbs_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  logic            i_kind,
    output logic            o_ready,
    input  hbs_pkg::t_dp_sts i_sts,
    output hbs_pkg::t_dp_cmd o_cmd
);
    import hbs_pkg::*;

    typedef enum logic [9:0] {
        S_IDLE = 10'b0000000001,
        S_RD0  = 10'b0000000010,
        S_RD1  = 10'b0000000100,
        S_RD2  = 10'b0000001000,
        S_RD3  = 10'b0000010000,
        S_RD4  = 10'b0000100000,
        S_MZ   = 10'b0001000000,
        S_SC   = 10'b0010000000,
        S_DV   = 10'b0100000000,
        S_OUT  = 10'b1000000000
    } t_state;

    t_state r_state, n_state;
    logic   accept;

    assign o_ready = (r_state == S_IDLE);
    assign accept  = i_valid && o_ready;

    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                o_cmd.write   = accept && (i_kind == KIND_LOAD);
                o_cmd.capture = accept && (i_kind == KIND_QUERY);
                if (accept && (i_kind == KIND_QUERY)) begin
                    n_state = S_RD0;
                end
            end
            S_RD0: begin
                o_cmd.rd_en  = 1'b1;
                o_cmd.corner = CORNER_A00;
                n_state      = i_sts.outside ? S_OUT : S_RD1;
            end
            S_RD1: begin
                // a00 comes back while a01 is addressed
                o_cmd.rd_en  = 1'b1;
                o_cmd.corner = CORNER_A01;
                o_cmd.lat_a  = 1'b1;
                n_state      = S_RD2;
            end
            S_RD2: begin
                o_cmd.rd_en  = 1'b1;
                o_cmd.corner = CORNER_A10;
                o_cmd.h0_en  = 1'b1;
                n_state      = S_RD3;
            end
            S_RD3: begin
                o_cmd.rd_en  = 1'b1;
                o_cmd.corner = CORNER_A11;
                o_cmd.lat_a  = 1'b1;
                n_state      = S_RD4;
            end
            S_RD4: begin
                o_cmd.h1_en = 1'b1;
                n_state     = S_MZ;
            end
            S_MZ: begin
                o_cmd.hz_en = 1'b1;
                n_state     = S_SC;
            end
            S_SC: begin
                o_cmd.scl_en = 1'b1;
                n_state      = S_DV;
            end
            S_DV: begin
                o_cmd.div_en = 1'b1;
                n_state      = S_OUT;
            end
            S_OUT: begin
                if (!i_sts.out_stall) begin
                    o_cmd.push = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    `HBS_ASSERT_IMP(a_push_free, i_clk, i_rst_n, o_cmd.push, !i_sts.out_stall, "push into a held result")
    `HBS_ASSERT_NXT(a_query_start, i_clk, i_rst_n, accept && (i_kind == KIND_QUERY), r_state == S_RD0, "query beat did not start reads")
    `HBS_ASSERT_NXT(a_load_stays, i_clk, i_rst_n, accept && (i_kind == KIND_LOAD), r_state == S_IDLE, "load beat left idle")
    `HBS_ASSERT_NXT(a_push_return, i_clk, i_rst_n, o_cmd.push, r_state == S_IDLE, "no return to idle after push")
endmodule

### sv/hbs_datapath.sv
// datapath of the heightmap sampler: config registers, grid split, store,
// bilinear blend, scale, divide by 255, offset and output register
// depends on hbs_pkg and hbs_ram
module hbs_datapath #(
    parameter int MAP_SIDE = 256
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  hbs_pkg::t_dp_cmd              i_cmd,
    output hbs_pkg::t_dp_sts              o_sts,
    input  logic                          i_cfg_we,
    input  hbs_pkg::t_cfg_idx             i_cfg_idx,
    input  logic [hbs_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic [7:0]                    i_cell_col,
    input  logic [7:0]                    i_cell_row,
    input  logic [7:0]                    i_sample,
    input  logic [15:0]                   i_world_x,
    input  logic [15:0]                   i_world_z,
    input  logic                          i_out_ready,
    output logic                          o_out_valid,
    output logic signed [16:0]            o_height_value,
    output logic                          o_outside
);
    import hbs_pkg::*;

    localparam int WW    = $clog2(MAP_SIDE + 1);
    localparam int TW    = (((WW + 7) > 15) ? (WW + 7) : 15) + 2;
    localparam int GW    = TW - 9;
    localparam int IW    = $clog2(MAP_SIDE);
    localparam int DEPTH = MAP_SIDE * MAP_SIDE;
    localparam int AW    = $clog2(DEPTH);

    typedef struct packed {
        logic          off;
        logic [IW-1:0] grid;
        logic [7:0]    frac;
    } t_axis;

    function automatic logic [WW-1:0] clamp_side(input logic [8:0] n);
        if ({23'd0, n} > 32'(MAP_SIDE)) begin
            return WW'(MAP_SIDE);
        end
        return WW'(n);
    endfunction

    // recentre, split into cell and fraction, flag off-grid or last cell
    function automatic t_axis split_axis(input logic [15:0] coord, input logic [WW-1:0] n);
        logic [TW-1:0] t;
        logic [GW-1:0] g;
        logic [GW:0]   g1;
        t_axis         a;
        t      = {{(TW-16){coord[15]}}, coord} + {{(TW-WW-7){1'b0}}, n, 7'd0};
        g      = t[TW-2:8];
        g1     = {1'b0, g} + (GW+1)'(1);
        a.off  = t[TW-1] | (g1 >= (GW+1)'(n));
        a.grid = IW'(g);
        a.frac = t[7:0];
        return a;
    endfunction

    function automatic logic [AW-1:0] cell_addr(input logic [IW-1:0] col,
                                                input logic [IW-1:0] row);
        return AW'(col) * AW'(MAP_SIDE) + AW'(row);
    endfunction

    logic [8:0]  r_map_width, r_map_depth;
    logic [14:0] r_scale;
    logic [15:0] r_offset;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_map_width <= RST_MAP_WIDTH;
            r_map_depth <= RST_MAP_DEPTH;
            r_scale     <= RST_HEIGHT_SCALE;
            r_offset    <= RST_HEIGHT_OFFSET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_MAP_WIDTH:     r_map_width <= i_cfg_data[8:0];
                CFG_MAP_DEPTH:     r_map_depth <= i_cfg_data[8:0];
                CFG_HEIGHT_SCALE:  r_scale     <= i_cfg_data[14:0];
                CFG_HEIGHT_OFFSET: r_offset    <= i_cfg_data;
            endcase
        end
    end

    t_axis ax, az;
    assign ax = split_axis(i_world_x, clamp_side(r_map_width));
    assign az = split_axis(i_world_z, clamp_side(r_map_depth));

    logic [IW-1:0] r_gx, r_gz;
    logic [7:0]    r_fx, r_fz;
    logic          r_outside;

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_gx      <= ax.grid;
            r_gz      <= az.grid;
            r_fx      <= ax.frac;
            r_fz      <= az.frac;
            r_outside <= ax.off | az.off;
        end
    end

    // store port: loads in idle, corner reads during a query
    logic          wr_ok;
    logic [IW-1:0] rd_col, rd_row;
    logic [AW-1:0] ram_addr;
    logic          ram_en;
    logic [7:0]    rd_data;

    assign wr_ok = i_cmd.write && ({24'd0, i_cell_col} < 32'(MAP_SIDE))
                               && ({24'd0, i_cell_row} < 32'(MAP_SIDE));
    assign rd_col   = r_gx + IW'(i_cmd.corner[0]);
    assign rd_row   = r_gz + IW'(i_cmd.corner[1]);
    assign ram_en   = wr_ok | (i_cmd.rd_en & !r_outside);
    assign ram_addr = wr_ok ? cell_addr(IW'(i_cell_col), IW'(i_cell_row))
                            : cell_addr(rd_col, rd_row);

    hbs_ram #(
        .WIDTH (8),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_en    (ram_en),
        .i_we    (wr_ok),
        .i_addr  (ram_addr),
        .i_wdata (i_sample),
        .o_rdata (rd_data)
    );

    logic [7:0]  r_a;
    logic [15:0] r_h0, r_h1;
    logic [23:0] r_h;
    logic [22:0] r_q1;
    logic [15:0] r_q;
    logic [38:0] scaled;
    logic [47:0] recip_prod;

    assign scaled     = 39'(r_h) * 39'(r_scale);
    assign recip_prod = 48'(r_q1) * 48'(RECIP_255);

    always_ff @(posedge i_clk) begin
        if (i_cmd.lat_a) begin
            r_a <= rd_data;
        end
        if (i_cmd.h0_en) begin
            r_h0 <= lerp8(r_a, rd_data, r_fx);
        end
        if (i_cmd.h1_en) begin
            r_h1 <= lerp8(r_a, rd_data, r_fx);
        end
        if (i_cmd.hz_en) begin
            r_h <= lerp16(r_h0, r_h1, r_fz);
        end
        // floor by 2^16 first, then by 255 through the reciprocal
        if (i_cmd.scl_en) begin
            r_q1 <= scaled[38:16];
        end
        if (i_cmd.div_en) begin
            r_q <= recip_prod[47:32];
        end
    end

    logic        r_out_valid;
    logic [16:0] r_out_height;
    logic        r_out_outside;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.push) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            r_out_height  <= r_outside ? 17'd0 : ({1'b0, r_q} + {r_offset[15], r_offset});
            r_out_outside <= r_outside;
        end
    end

    assign o_sts.outside   = r_outside;
    assign o_sts.out_stall = r_out_valid & !i_out_ready;
    assign o_out_valid     = r_out_valid;
    assign o_height_value  = r_out_height;
    assign o_outside       = r_out_outside;
endmodule

### sv/heightmap_bilinear_sampler_core.sv
// top level of the heightmap bilinear sampler
// depends on hbs_pkg, hbs_in_if, hbs_out_if, hbs_ctrl, hbs_datapath
//
//  channel    dir  fields                                         beat
//  i_item     in   kind cell_col cell_row sample world_x world_z  valid & ready
//  o_result   out  height_value outside                           valid & ready
//  i_cfg_*    in   idx data                                       i_cfg_we
//
// a load beat leaves the sequencer idle; a query on the grid holds the input
// through four reads through the single store port and the blend, scale and
// divide steps, and off the grid goes from the first read straight to the output.
// the input is ready only between items; a finished result waits in the output
// register, so a stalled result channel blocks only the next query's last step.
// reset clears the sequencer and output valid and loads the config defaults;
// the store has no clearing pass and holds unknown data until loaded.
module heightmap_bilinear_sampler_core #(
    parameter int MAP_SIDE = 256
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    hbs_in_if.sink                         i_item,
    hbs_out_if.source                      o_result,
    input  logic                           i_cfg_we,
    input  hbs_pkg::t_cfg_idx              i_cfg_idx,
    input  logic [hbs_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import hbs_pkg::*;

    t_dp_cmd cmd;
    t_dp_sts sts;

    hbs_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_item.valid),
        .i_kind  (i_item.kind),
        .o_ready (i_item.ready),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    hbs_datapath #(
        .MAP_SIDE (MAP_SIDE)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_cell_col     (i_item.cell_col),
        .i_cell_row     (i_item.cell_row),
        .i_sample       (i_item.sample),
        .i_world_x      (i_item.world_x),
        .i_world_z      (i_item.world_z),
        .i_out_ready    (o_result.ready),
        .o_out_valid    (o_result.valid),
        .o_height_value (o_result.height_value),
        .o_outside      (o_result.outside)
    );
endmodule

### bench/hbs_height_checker.sv
// watches the item, result and config ports of the heightmap sampler and predicts each height
// keeps its own copy of the store and registers; depends on hbs_pkg, hbs_in_if, hbs_out_if
`timescale 1ns / 100ps

module hbs_height_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    hbs_in_if                              i_item,
    hbs_out_if                             i_result,
    input  logic                           i_cfg_we,
    input  hbs_pkg::t_cfg_idx              i_cfg_idx,
    input  logic [hbs_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output int                             o_err_count,
    output int                             o_pending
);
    import hbs_pkg::*;

    localparam int SIDE = 256;

    typedef struct packed {
        logic signed [16:0] height_value;
        logic               outside;
    } t_height_result;

    logic [7:0]         height_cells [0:SIDE*SIDE-1];
    logic [8:0]         cols_used;
    logic [8:0]         rows_used;
    logic [14:0]        scale_q8;
    logic signed [15:0] offset_q8;
    t_height_result     expected_heights [$];
    int                 mismatches;

    function automatic longint unsigned cell_at(input int col, input int row);
        return longint'(height_cells[col*SIDE + row]);
    endfunction

    function automatic t_height_result sample_height(input logic signed [15:0] wx,
                                                     input logic signed [15:0] wz);
        int                w, d, tx, tz, gx, gz;
        longint unsigned   fx, fz, h0, h1, h, scaled;
        t_height_result    res;
        res.height_value = '0;
        res.outside      = 1'b1;
        w  = (cols_used > SIDE) ? SIDE : int'(cols_used);
        d  = (rows_used > SIDE) ? SIDE : int'(rows_used);
        tx = int'(wx) + w*128;
        tz = int'(wz) + d*128;
        if (tx < 0 || tz < 0)
            return res;
        gx = tx / 256;
        gz = tz / 256;
        // also catches maps narrower than two cells
        if (gx >= w-1 || gz >= d-1)
            return res;
        fx = longint'(tx % 256);
        fz = longint'(tz % 256);
        h0 = cell_at(gx, gz)*(256-fx) + cell_at(gx+1, gz)*fx;
        h1 = cell_at(gx, gz+1)*(256-fx) + cell_at(gx+1, gz+1)*fx;
        h  = h0*(256-fz) + h1*fz;
        scaled = h * longint'(scale_q8) / (255*65536);
        res.height_value = 17'(longint'(scaled) + longint'(offset_q8));
        res.outside      = 1'b0;
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_height_result exp_res;
        if (!i_rst_n) begin
            cols_used  = RST_MAP_WIDTH;
            rows_used  = RST_MAP_DEPTH;
            scale_q8   = RST_HEIGHT_SCALE;
            offset_q8  = RST_HEIGHT_OFFSET;
            mismatches = 0;
            expected_heights.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_MAP_WIDTH:     cols_used = i_cfg_data[8:0];
                    CFG_MAP_DEPTH:     rows_used = i_cfg_data[8:0];
                    CFG_HEIGHT_SCALE:  scale_q8  = i_cfg_data[14:0];
                    CFG_HEIGHT_OFFSET: offset_q8 = i_cfg_data[15:0];
                    default: ;
                endcase
            end
            if (i_item.valid && i_item.ready) begin
                if (i_item.kind == KIND_LOAD)
                    height_cells[{i_item.cell_col, i_item.cell_row}] = i_item.sample;
                else
                    expected_heights.insert(expected_heights.size(),
                                            sample_height(i_item.world_x, i_item.world_z));
            end
            if (i_result.valid && i_result.ready) begin
                if (expected_heights.size() == 0) begin
                    mismatches++;
                    $display("%0t: unexpected result beat, height_value %0d outside %0b",
                             $time, i_result.height_value, i_result.outside);
                end else begin
                    exp_res = expected_heights.pop_front();
                    if (i_result.height_value !== exp_res.height_value) begin
                        mismatches++;
                        $display("%0t: height_value expected %0d actual %0d", $time,
                                 exp_res.height_value, i_result.height_value);
                    end
                    if (i_result.outside !== exp_res.outside) begin
                        mismatches++;
                        $display("%0t: outside expected %0b actual %0b", $time,
                                 exp_res.outside, i_result.outside);
                    end
                end
            end
        end
        o_err_count = mismatches;
        o_pending   = expected_heights.size();
    end

endmodule

### bench/tb_heightmap_bilinear_sampler_core.sv
// stimulus and verdict for the heightmap bilinear sampler: directed corners, then random phases
// depends on hbs_pkg, hbs_in_if, hbs_out_if, heightmap_bilinear_sampler_core, hbs_height_checker
`timescale 1ns / 100ps

module tb_heightmap_bilinear_sampler_core;
    import hbs_pkg::*;

    localparam int SIDE         = 256;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 24;
    localparam int GAP_MAX      = 16;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    t_cfg_idx              cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;
    int                    err_count;
    int                    pending;

    bit loaded [0:SIDE*SIDE-1];
    int cur_width;
    int cur_depth;
    bit send_idle;
    bit recv_idle;
    bit hold_req;

    hbs_in_if  item_if();
    hbs_out_if res_if();

    heightmap_bilinear_sampler_core #(.MAP_SIDE(SIDE)) dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_item     (item_if),
        .o_result   (res_if),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    hbs_height_checker u_height_check (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_item      (item_if),
        .i_result    (res_if),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data),
        .o_err_count (err_count),
        .o_pending   (pending)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial begin
        #5_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    // result side: random stalls while recv_idle is set, plus one long hold-off on request
    initial begin
        res_if.ready <= 1'b0;
        @(posedge clk);
        forever begin
            if (hold_req) begin
                res_if.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 1'b0;
            end else if (recv_idle && $urandom_range(0, 7) == 0) begin
                res_if.ready <= 1'b0;
                repeat ($urandom_range(1, GAP_MAX)) @(posedge clk);
            end else begin
                res_if.ready <= 1'b1;
                @(posedge clk);
            end
        end
    end

    function automatic logic [7:0] pick_sample();
        case ($urandom_range(0, 5))
            0:       return 8'd0;
            1:       return 8'd255;
            default: return 8'($urandom);
        endcase
    endfunction

    // lands mostly on usable grid cells, edges included, at times on the last cell, sometimes anywhere
    function automatic logic signed [15:0] aim_coord(input int n);
        int side;
        int g;
        side = (n > SIDE) ? SIDE : n;
        if (side < 2 || $urandom_range(0, 4) == 0)
            return 16'($urandom);
        case ($urandom_range(0, 4))
            0:       g = 0;
            1:       g = side - 2;
            2:       g = side - 1;
            default: g = $urandom_range(0, side - 2);
        endcase
        return 16'(g*256 + int'($urandom_range(0, 255)) - side*128);
    endfunction

    task automatic offer_beat(input logic kind, input logic [7:0] col, input logic [7:0] row,
                              input logic [7:0] smp, input logic signed [15:0] wx,
                              input logic signed [15:0] wz);
        if (send_idle && $urandom_range(0, 3) == 0) begin
            item_if.valid <= 1'b0;
            repeat ($urandom_range(1, GAP_MAX)) @(posedge clk);
        end
        item_if.valid    <= 1'b1;
        item_if.kind     <= kind;
        item_if.cell_col <= col;
        item_if.cell_row <= row;
        item_if.sample   <= smp;
        item_if.world_x  <= wx;
        item_if.world_z  <= wz;
        do @(posedge clk); while (!item_if.ready);
    endtask

    task automatic load_cell(input logic [7:0] col, input logic [7:0] row,
                             input logic [7:0] smp);
        offer_beat(KIND_LOAD, col, row, smp, 16'($urandom), 16'($urandom));
        loaded[{col, row}] = 1'b1;
    endtask

    // loads any corner the query would read that was never written, then queries
    task automatic query_height(input logic signed [15:0] wx, input logic signed [15:0] wz,
                                output int beats);
        int w, d, tx, tz, gx, gz;
        beats = 1;
        w  = (cur_width > SIDE) ? SIDE : cur_width;
        d  = (cur_depth > SIDE) ? SIDE : cur_depth;
        tx = int'(wx) + w*128;
        tz = int'(wz) + d*128;
        gx = tx / 256;
        gz = tz / 256;
        if (tx >= 0 && tz >= 0 && gx < w-1 && gz < d-1) begin
            for (int dc = 0; dc < 2; dc++) begin
                for (int dr = 0; dr < 2; dr++) begin
                    if (!loaded[(gx+dc)*SIDE + gz + dr]) begin
                        load_cell(8'(gx+dc), 8'(gz+dr), pick_sample());
                        beats++;
                    end
                end
            end
        end
        offer_beat(KIND_QUERY, 8'($urandom), 8'($urandom), 8'($urandom), wx, wz);
    endtask

    task automatic set_config(input int w, input int d, input int scale, input int offset);
        cfg_we   <= 1'b1;
        cfg_idx  <= CFG_MAP_WIDTH;
        cfg_data <= 16'(w);
        @(posedge clk);
        cfg_idx  <= CFG_MAP_DEPTH;
        cfg_data <= 16'(d);
        @(posedge clk);
        cfg_idx  <= CFG_HEIGHT_SCALE;
        cfg_data <= 16'(scale);
        @(posedge clk);
        cfg_idx  <= CFG_HEIGHT_OFFSET;
        cfg_data <= 16'(offset);
        @(posedge clk);
        cfg_we   <= 1'b0;
        cur_width = w % 512;
        cur_depth = d % 512;
    endtask

    // sender pauses until every height is back and the block has gone quiet
    task automatic settle();
        item_if.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic run_phase(input int w, input int d, input int scale, input int offset,
                             input int beats, input bit idle, input bit hold);
        int sent;
        int n;
        settle();
        set_config(w, d, scale, offset);
        send_idle = idle;
        recv_idle = idle;
        if (hold)
            hold_req = 1'b1;
        sent = 0;
        while (sent < beats) begin
            if ($urandom_range(0, 3) == 0) begin
                load_cell(8'($urandom), 8'($urandom), pick_sample());
                sent++;
            end else begin
                query_height(aim_coord(cur_width), aim_coord(cur_depth), n);
                sent += n;
            end
        end
    endtask

    initial begin
        int n;
        int waited;
        rst_n            <= 1'b0;
        cfg_we           <= 1'b0;
        cfg_idx          <= CFG_MAP_WIDTH;
        cfg_data         <= '0;
        item_if.valid    <= 1'b0;
        item_if.kind     <= KIND_LOAD;
        item_if.cell_col <= '0;
        item_if.cell_row <= '0;
        item_if.sample   <= '0;
        item_if.world_x  <= '0;
        item_if.world_z  <= '0;
        cur_width = int'(RST_MAP_WIDTH);
        cur_depth = int'(RST_MAP_DEPTH);
        send_idle = 1'b0;
        recv_idle = 1'b0;
        hold_req  = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset registers: first and last usable cells, fractions at both ends
        load_cell(8'd0, 8'd0, 8'd0);
        load_cell(8'd1, 8'd0, 8'd255);
        load_cell(8'd0, 8'd1, 8'd255);
        load_cell(8'd1, 8'd1, 8'd0);
        query_height(-16'sd32768, -16'sd32768, n);
        query_height(-16'sd32640, -16'sd32513, n);
        load_cell(8'd254, 8'd254, 8'd255);
        load_cell(8'd255, 8'd254, 8'd255);
        load_cell(8'd254, 8'd255, 8'd255);
        load_cell(8'd255, 8'd255, 8'd255);
        query_height(16'sd32511, 16'sd32511, n);
        // off the grid past the last column, past the last row, and both
        query_height(16'sd32512, -16'sd32768, n);
        query_height(-16'sd32768, 16'sd32767, n);
        query_height(16'sd32767, 16'sd32767, n);
        // grid centre, with and without fraction, then one point away from the centre
        query_height(16'sd0, 16'sd0, n);
        query_height(-16'sd1, -16'sd1, n);
        query_height(16'sh5555, -16'sh2AAB, n);

        run_phase(256, 256, 16384, -7680, 250, 1'b1, 1'b0);
        run_phase(2, 2, 32767, 32767, 120, 1'b1, 1'b0);
        run_phase(16, 9, 25600, -25600, 250, 1'b1, 1'b1);
        run_phase(511, 300, 0, -32768, 150, 1'b1, 1'b0);
        run_phase(1, 40, 1000, 0, 80, 1'b1, 1'b0);
        run_phase(0, 0, 200, 25600, 60, 1'b1, 1'b0);
        run_phase(40, 2, 32767, -32768, 200, 1'b1, 1'b0);
        run_phase(257, 3, 12345, 100, 200, 1'b1, 1'b0);
        run_phase(64, 1, 5000, -5000, 60, 1'b0, 1'b0);
        run_phase(64, 64, 16384, -7680, 300, 1'b0, 1'b0);
        run_phase(256, 256, 32767, 32767, 250, 1'b0, 1'b0);

        item_if.valid <= 1'b0;
        @(posedge clk);
        waited = 0;
        while (pending != 0 && waited < 10000) begin
            @(posedge clk);
            waited++;
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (err_count == 0 && pending == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

### filelist.f
+incdir+sv
sv/hbs_pkg.sv
sv/hbs_in_if.sv
sv/hbs_out_if.sv
sv/hbs_ram.sv
sv/hbs_ctrl.sv
sv/hbs_datapath.sv
sv/heightmap_bilinear_sampler_core.sv
bench/hbs_height_checker.sv
bench/tb_heightmap_bilinear_sampler_core.sv
